FILE: design/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
package m3i_pkg;

    // Number of matrix elements in one transaction.
    localparam int unsigned NUM_ELEMS = 9;

    // Cofactor k = a[p]*a[q] - a[r]*a[s], with the matrix index row*3+col.
    localparam int unsigned COF_IDX [NUM_ELEMS][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

FILE: design/m3i_mat_if.sv
// ----------------------------------------------------------------------------
// m3i_mat_if
// Input channel: one 3x3 matrix of signed fixed-point elements.
// ----------------------------------------------------------------------------
interface m3i_mat_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] m00;
    logic signed [W-1:0] m01;
    logic signed [W-1:0] m02;
    logic signed [W-1:0] m10;
    logic signed [W-1:0] m11;
    logic signed [W-1:0] m12;
    logic signed [W-1:0] m20;
    logic signed [W-1:0] m21;
    logic signed [W-1:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

FILE: design/m3i_inv_if.sv
// ----------------------------------------------------------------------------
// m3i_inv_if
// Output channel: the inverse matrix, the determinant and a singular flag.
// ----------------------------------------------------------------------------
interface m3i_inv_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] inv00;
    logic signed [W-1:0] inv01;
    logic signed [W-1:0] inv02;
    logic signed [W-1:0] inv10;
    logic signed [W-1:0] inv11;
    logic signed [W-1:0] inv12;
    logic signed [W-1:0] inv20;
    logic signed [W-1:0] inv21;
    logic signed [W-1:0] inv22;
    logic signed [W-1:0] determinant;
    logic                singular;

    modport source (
        output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
               inv22, determinant, singular,
        input  ready
    );
    modport sink (
        input  valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
               inv22, determinant, singular,
        output ready
    );
endinterface

FILE: design/mat3_determinant_inverse_unit.sv
// ----------------------------------------------------------------------------
// mat3_determinant_inverse_unit
// Inverts a 3x3 fixed-point matrix by the adjugate method and reports the
// determinant and a singular flag.
// ----------------------------------------------------------------------------
// The unit accepts one matrix per clock cycle while it is not stalled and
// returns each result in order. Most of the pipeline lies in the nine long
// dividers, which resolve one quotient bit per pipeline stage; ahead of them
// sit six stages for the cofactor products, the cofactors, the split
// determinant products, their recombination, the determinant sum and the
// sign-magnitude step. The whole pipeline advances together and stops only
// while a finished result waits at the output and the sink is not ready. A
// zero determinant raises singular and forces all inverse elements to zero.
// ----------------------------------------------------------------------------
module mat3_determinant_inverse_unit
    import m3i_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    m3i_mat_if.sink       mat_in,
    m3i_inv_if.source     inv_out
);

    localparam int W    = ELEM_WIDTH;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int HW   = CW - W;
    localparam int TW   = W + HW;
    localparam int DW   = 3 * W + 3;
    localparam int NW   = CW + 2 * FRAC_BITS;
    localparam int NSTG = 6 + NW + 1;

    logic en;
    logic [NSTG-1:0] valid_reg;

    assign en           = !inv_out.valid || inv_out.ready;
    assign mat_in.ready = en;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], mat_in.valid};
        end
    end

    logic signed [W-1:0] a [NUM_ELEMS];

    assign a[0] = mat_in.m00;
    assign a[1] = mat_in.m01;
    assign a[2] = mat_in.m02;
    assign a[3] = mat_in.m10;
    assign a[4] = mat_in.m11;
    assign a[5] = mat_in.m12;
    assign a[6] = mat_in.m20;
    assign a[7] = mat_in.m21;
    assign a[8] = mat_in.m22;

    // Stage 1: the two products of every cofactor.
    logic signed [PW-1:0] prod_p_reg [NUM_ELEMS];
    logic signed [PW-1:0] prod_q_reg [NUM_ELEMS];
    logic signed [W-1:0]  row1_reg   [3];
    logic signed [W-1:0]  row2_reg   [3];

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_p_reg[k] <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
                prod_q_reg[k] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
            end
        end
    end

    // Stage 2: the cofactors.
    logic signed [CW-1:0] cof_reg [NUM_ELEMS];

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cof
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cof_reg[k] <= CW'(prod_p_reg[k]) - CW'(prod_q_reg[k]);
            end
        end
    end

    // The first row follows the cofactors for the determinant expansion.
    for (genvar j = 0; j < 3; j++) begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row1_reg[j] <= a[j];
                row2_reg[j] <= row1_reg[j];
            end
        end
    end

    // Stage 3: each first-row term split into low and high partial products.
    logic signed [TW-1:0] lo_reg   [3];
    logic signed [TW-1:0] hi_reg   [3];
    logic signed [CW-1:0] cof3_reg [NUM_ELEMS];

    for (genvar j = 0; j < 3; j++) begin : g_split
        logic signed [HW-1:0] cof_lo;
        logic signed [HW-1:0] cof_hi;

        assign cof_lo = signed'({1'b0, cof_reg[3*j][W-1:0]});
        assign cof_hi = cof_reg[3*j][CW-1:W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[j] <= row2_reg[j] * cof_lo;
                hi_reg[j] <= row2_reg[j] * cof_hi;
            end
        end
    end

    // Stage 4: recombine the partial products of each term.
    logic signed [DW-1:0] term_reg [3];
    logic signed [CW-1:0] cof4_reg [NUM_ELEMS];

    for (genvar j = 0; j < 3; j++) begin : g_term
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[j] <= (DW'(hi_reg[j]) <<< W) + DW'(lo_reg[j]);
            end
        end
    end

    // Stage 5: the exact determinant.
    logic signed [DW-1:0] det_reg;
    logic signed [CW-1:0] cof5_reg [NUM_ELEMS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cofdly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cof3_reg[k] <= cof_reg[k];
                cof4_reg[k] <= cof3_reg[k];
                cof5_reg[k] <= cof4_reg[k];
            end
        end
    end

    // Stage 6: sign and magnitude for the dividers, determinant result.
    logic          det_neg;
    logic [DW-1:0] det_mag;
    logic [DW-1:0] det_shr;
    logic [W-1:0]  det_lim;
    logic [W-1:0]  det_sat;
    logic          det_over;

    always_comb
    begin
        det_neg  = det_reg[DW-1];
        det_mag  = det_neg ? DW'(-det_reg) : DW'(det_reg);
        det_shr  = det_mag >> (2 * FRAC_BITS);
        det_over = |det_shr[DW-1:W];
        det_lim  = det_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        det_sat  = (det_over || (det_shr[W-1:0] > det_lim)) ? det_lim
                                                             : det_shr[W-1:0];
    end

    logic [NW-1:0]        num_reg  [NUM_ELEMS];
    logic                 neg_reg  [NUM_ELEMS];
    logic [DW-1:0]        den_reg;
    logic signed [W-1:0]  det6_reg;
    logic                 sing6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= det_mag;
            det6_reg  <= det_neg ? signed'(-det_sat) : signed'(det_sat);
            sing6_reg <= (det_reg == '0);
        end
    end

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_num
        logic [CW-1:0] cof_mag;

        assign cof_mag = cof5_reg[k][CW-1] ? CW'(-cof5_reg[k]) : CW'(cof5_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k] <= NW'(cof_mag) << (2 * FRAC_BITS);
                neg_reg[k] <= cof5_reg[k][CW-1] ^ det_neg;
            end
        end
    end

    // Dividers: one quotient bit per stage.
    logic signed [W-1:0] quo [NUM_ELEMS];

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_div
        m3i_div_lane #(
            .NW (NW),
            .DW (DW),
            .W  (W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[k]),
            .den (den_reg),
            .neg (neg_reg[k]),
            .quo (quo[k])
        );
    end

    // The determinant and the singular flag follow the dividers.
    logic signed [W-1:0] det_dly_reg  [NW];
    logic                sing_dly_reg [NW];

    for (genvar s = 0; s < NW; s++) begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                det_dly_reg[s]  <= (s == 0) ? det6_reg  : det_dly_reg[(s == 0) ? 0 : s-1];
                sing_dly_reg[s] <= (s == 0) ? sing6_reg : sing_dly_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // Output register: a singular matrix gives a zero inverse.
    logic signed [W-1:0] inv_reg [NUM_ELEMS];
    logic signed [W-1:0] det_out_reg;
    logic                sing_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                inv_reg[k] <= sing_dly_reg[NW-1] ? '0 : quo[k];
            end
            det_out_reg  <= det_dly_reg[NW-1];
            sing_out_reg <= sing_dly_reg[NW-1];
        end
    end

    assign inv_out.valid       = valid_reg[NSTG-1];
    assign inv_out.inv00       = inv_reg[0];
    assign inv_out.inv01       = inv_reg[1];
    assign inv_out.inv02       = inv_reg[2];
    assign inv_out.inv10       = inv_reg[3];
    assign inv_out.inv11       = inv_reg[4];
    assign inv_out.inv12       = inv_reg[5];
    assign inv_out.inv20       = inv_reg[6];
    assign inv_out.inv21       = inv_reg[7];
    assign inv_out.inv22       = inv_reg[8];
    assign inv_out.determinant = det_out_reg;
    assign inv_out.singular    = sing_out_reg;

`ifndef ASSERT_OFF
    // A stalled pipeline holds all its transactions in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    // A singular result carries a zero inverse; the check covers inv00, inv01, inv11, inv12, inv20 and inv22.
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_out.valid && inv_out.singular |->
            inv_out.inv00 == '0 && inv_out.inv11 == '0 && inv_out.inv22 == '0 &&
            inv_out.inv01 == '0 && inv_out.inv12 == '0 && inv_out.inv20 == '0)
        else $error("singular result with nonzero inverse");

    // A singular result reports a zero determinant.
    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        inv_out.valid && inv_out.singular |-> inv_out.determinant == '0)
        else $error("singular result with nonzero determinant");
`endif

endmodule

FILE: design/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider: one quotient bit per stage, followed by
// signed saturation of the quotient to W bits.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
    parameter int NW = 97,
    parameter int DW = 99,
    parameter int W  = 32
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  logic                neg,
    output logic signed [W-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [W-1:0]  q_reg   [NW];
    logic          ovf_reg [NW];
    logic          neg_reg [NW];

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [W-1:0]  q_in;
        logic          ovf_in;
        logic          neg_in;
        logic [DW:0]   rem_sh;
        logic          take;
        logic [DW:0]   rem_sub;
        logic [DW-1:0] rem_next;
        logic [W-1:0]  q_next;
        logic          ovf_next;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign ovf_in = 1'b0;
            assign neg_in = neg;
        end
        else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign ovf_in = ovf_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        always_comb
        begin
            rem_sh   = {rem_in, num_in[NW-1]};
            take     = (rem_sh >= {1'b0, den_in});
            rem_sub  = rem_sh - {1'b0, den_in};
            rem_next = take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            // A bit that leaves the W-bit window means the quotient overflows.
            q_next   = {q_in[W-2:0], take};
            ovf_next = ovf_in | q_in[W-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                num_reg[s] <= {num_in[NW-2:0], 1'b0};
                den_reg[s] <= den_in;
                q_reg[s]   <= q_next;
                ovf_reg[s] <= ovf_next;
                neg_reg[s] <= neg_in;
            end
        end
    end

    // Clamp the magnitude and apply the sign.
    logic [W-1:0] lim;
    logic [W-1:0] mag;

    always_comb
    begin
        lim = neg_reg[NW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        mag = (ovf_reg[NW-1] || (q_reg[NW-1] > lim)) ? lim : q_reg[NW-1];
        quo = neg_reg[NW-1] ? signed'(-mag) : signed'(mag);
    end

endmodule

FILE: tb/mat3_determinant_inverse_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat3_determinant_inverse_unit_test
// Self-checking testbench for the 3x3 matrix inverse unit. Matrices are sent
// on the input channel with random gaps, an internal predictor works out the
// inverse, determinant and singular flag for each accepted transaction, and
// every output transaction is compared field by field in order.
// ----------------------------------------------------------------------------
module mat3_determinant_inverse_unit_test;
    import m3i_pkg::*;

    localparam int W          = 32;
    localparam int FRAC       = 16;
    localparam int LATENCY    = 7 + 2 * W + 1 + 2 * FRAC;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 850;
    localparam int HOLD_LEN   = 300;

    typedef logic signed [W-1:0]  elem_t;
    typedef logic signed [255:0]  wide_t;

    typedef struct {
        elem_t m [NUM_ELEMS];
    } matrix_t;

    typedef struct {
        elem_t inv [NUM_ELEMS];
        elem_t det;
        logic  sing;
    } inverse_t;

    logic clk;
    logic rst_n;

    m3i_mat_if #(.W(W)) mat_if ();
    m3i_inv_if #(.W(W)) inv_if ();

    mat3_determinant_inverse_unit #(
        .ELEM_WIDTH (W),
        .FRAC_BITS  (FRAC)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .mat_in  (mat_if),
        .inv_out (inv_if)
    );

    inverse_t expected_inverses [$];
    int       error_count;
    int       cycle_count;
    int       sent_count;
    int       checked_count;
    int       singular_seen;
    logic     hold_off_request = 1'b0;
    logic     hold_off_active  = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Clamp a wide value to the signed element range.
    function automatic elem_t clamp_elem(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (W - 1)) - 1;
        lo = -(wide_t'(1) <<< (W - 1));
        if (v > hi)
            return elem_t'(hi);
        if (v < lo)
            return elem_t'(lo);
        return elem_t'(v);
    endfunction

    // Exact adjugate inverse with truncation toward zero and saturation.
    function automatic inverse_t invert_matrix(matrix_t a);
        wide_t    w [NUM_ELEMS];
        wide_t    cof [NUM_ELEMS];
        wide_t    dsum;
        inverse_t r;
        for (int k = 0; k < NUM_ELEMS; k++)
            w[k] = a.m[k];
        for (int k = 0; k < NUM_ELEMS; k++)
            cof[k] = w[COF_IDX[k][0]] * w[COF_IDX[k][1]]
                   - w[COF_IDX[k][2]] * w[COF_IDX[k][3]];
        dsum  = w[0] * cof[0] + w[1] * cof[3] + w[2] * cof[6];
        r.det = clamp_elem(dsum / (wide_t'(1) <<< (2 * FRAC)));
        r.sing = (dsum == 0);
        for (int k = 0; k < NUM_ELEMS; k++)
            r.inv[k] = r.sing ? elem_t'(0)
                              : clamp_elem((cof[k] <<< (2 * FRAC)) / dsum);
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // One random element in the requested style.
    function automatic elem_t pick_elem(int style);
        case (style)
            0:       return elem_t'($urandom);
            1:       return elem_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            2:       return elem_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17)
                                    + (1 << FRAC));
            default: return elem_t'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // Count and print one mismatch.
    task automatic report_mismatch(string what, elem_t got, elem_t want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Offer one matrix after a gap and hold it until the transaction completes.
    task automatic send_matrix(matrix_t a, int gap);
        for (int g = 0; g < gap; g++)
        begin
            @(negedge clk);
            mat_if.valid <= 1'b0;
        end
        @(negedge clk);
        mat_if.valid <= 1'b1;
        mat_if.m00 <= a.m[0];
        mat_if.m01 <= a.m[1];
        mat_if.m02 <= a.m[2];
        mat_if.m10 <= a.m[3];
        mat_if.m11 <= a.m[4];
        mat_if.m12 <= a.m[5];
        mat_if.m20 <= a.m[6];
        mat_if.m21 <= a.m[7];
        mat_if.m22 <= a.m[8];
        do
            @(posedge clk);
        while (!mat_if.ready);
        expected_inverses.push_back(invert_matrix(a));
        sent_count++;
    endtask

    // Wait until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge clk);
        mat_if.valid <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge clk);
    endtask

    // Build a matrix from nine raw words.
    function automatic matrix_t make_matrix(elem_t e0, elem_t e1, elem_t e2,
                                            elem_t e3, elem_t e4, elem_t e5,
                                            elem_t e6, elem_t e7, elem_t e8);
        matrix_t a;
        a.m = '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
        return a;
    endfunction

    // Long receiver hold-off, counted in cycles once it is requested.
    initial
    begin
        wait (hold_off_request);
        @(negedge clk);
        hold_off_active <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off_active <= 1'b0;
    end

    // Receiver ready: random stalls, held low during the hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off_active)
        begin
            inv_if.ready <= 1'b0;
        end
        else
        begin
            inv_if.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // Output checker: compare each transaction with the oldest prediction.
    always @(posedge clk)
    begin
        inverse_t want;
        elem_t    got [NUM_ELEMS];
        if (rst_n && inv_if.valid && inv_if.ready)
        begin
            got = '{inv_if.inv00, inv_if.inv01, inv_if.inv02,
                    inv_if.inv10, inv_if.inv11, inv_if.inv12,
                    inv_if.inv20, inv_if.inv21, inv_if.inv22};
            if (expected_inverses.size() == 0)
            begin
                error_count++;
                $display("[%0t] output transaction with nothing expected", $realtime);
            end
            else
            begin
                want = expected_inverses.pop_front();
                checked_count++;
                if (want.sing)
                    singular_seen++;
                for (int k = 0; k < NUM_ELEMS; k++)
                    if (got[k] !== want.inv[k])
                        report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
                                        got[k], want.inv[k]);
                if (inv_if.determinant !== want.det)
                    report_mismatch("determinant", inv_if.determinant, want.det);
                if (inv_if.singular !== want.sing)
                    report_mismatch("singular", elem_t'(inv_if.singular),
                                    elem_t'(want.sing));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("mat3_determinant_inverse_unit_test: done, errors");
            $finish;
        end
    end

    // Directed corner matrices.
    task automatic test_directed();
        elem_t one;
        elem_t mx;
        elem_t mn;
        one = elem_t'(1 << FRAC);
        mx  = elem_t'(32'h7fff_ffff);
        mn  = elem_t'(32'h8000_0000);
        // Identity, a diagonal matrix and a negated identity.
        send_matrix(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one), 0);
        send_matrix(make_matrix(2 * one, 0, 0, 0, 4 * one, 0, 0, 0, -8 * one), 0);
        send_matrix(make_matrix(-one, 0, 0, 0, -one, 0, 0, 0, -one), 1);
        // Singular: all zero, repeated rows, all extremes.
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_matrix(make_matrix(one, 2, 3, one, 2, 3, 7, 8, 9), 0);
        send_matrix(make_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx), 2);
        send_matrix(make_matrix(mn, mn, mn, mn, mn, mn, mn, mn, mn), 0);
        // Tiny determinant that truncates to zero.
        send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1), 0);
        send_matrix(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1), 0);
        // Overflow of determinant and of inverse elements.
        send_matrix(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx), 0);
        send_matrix(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn), 0);
        send_matrix(make_matrix(mn, mx, 0, mx, mn, 0, 0, 0, mn), 3);
        send_matrix(make_matrix(mx, mn, mx, mn, mx, mn, mx, mn, 0), 0);
        send_matrix(make_matrix(1, 0, 0, 0, one, 0, 0, 0, one), 0);
        send_matrix(make_matrix(mx, 1, 0, 0, -1, 0, 0, 0, 1), 0);
        // Plain matrices: two well-conditioned ones and a small singular one.
        send_matrix(make_matrix(2 * one, one, 0, one, 3 * one, one, 0, one, 4 * one), 0);
        send_matrix(make_matrix(0, one, 0, 0, 0, one, one, 0, 0), 0);
        send_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -2), 0);
        wait_drained();
    endtask

    // Random matrices of mixed styles, some forced singular.
    task automatic test_random(int count);
        matrix_t a;
        int      style;
        int      p;
        for (int n = 0; n < count; n++)
        begin
            style = $urandom_range(0, 3);
            for (int k = 0; k < NUM_ELEMS; k++)
                a.m[k] = pick_elem($urandom_range(0, 9) == 0 ? 0 : style);
            p = $urandom_range(0, 9);
            // Duplicate a row or column to force a zero determinant.
            if (p == 0)
                for (int c = 0; c < 3; c++)
                    a.m[6 + c] = a.m[c];
            else if (p == 1)
                for (int r = 0; r < 3; r++)
                    a.m[r * 3 + 2] = a.m[r * 3];
            send_matrix(a, pick_gap());
        end
        wait_drained();
    endtask

    // Long receiver hold-off while the sender streams back to back.
    task automatic test_backpressure();
        matrix_t a;
        hold_off_request = 1'b1;
        for (int n = 0; n < 200; n++)
        begin
            for (int k = 0; k < NUM_ELEMS; k++)
                a.m[k] = pick_elem(n % 4);
            send_matrix(a, 0);
        end
        wait_drained();
    endtask

    // Main sequence.
    initial
    begin
        rst_n        <= 1'b0;
        mat_if.valid <= 1'b0;
        mat_if.m00 <= '0; mat_if.m01 <= '0; mat_if.m02 <= '0;
        mat_if.m10 <= '0; mat_if.m11 <= '0; mat_if.m12 <= '0;
        mat_if.m20 <= '0; mat_if.m21 <= '0; mat_if.m22 <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(N_RANDOM - 200);

        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d matrices, checked %0d results, %0d of them singular.",
                 sent_count, checked_count, singular_seen);
        $display("Covered corner values, forced singular cases and a long output stall.");
        if (error_count == 0 && expected_inverses.size() == 0)
            $display("mat3_determinant_inverse_unit_test: done, clean");
        else
            $display("mat3_determinant_inverse_unit_test: done, errors");
        $finish;
    end

endmodule
